/* rtl/keypad_infix_calculator_macros.svh */
// Assertion helpers shared by the calculator RTL.
// All checks are clocked on clk_i and are off while rst_ni is low.
`ifndef KEYPAD_INFIX_CALCULATOR_MACROS_SVH
`define KEYPAD_INFIX_CALCULATOR_MACROS_SVH

// Same-cycle implication.
`define KIC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("kic: same-cycle check failed");

// Next-cycle implication.
`define KIC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kic: next-cycle check failed");

`endif

/* rtl/kic_pkg.sv */
`default_nettype none

package kic_pkg;

  // Pending high-precedence operation
  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_MUL  = 2'd1,
    PEND_DIV  = 2'd2
  } pend_e;

  // Key classes after decoding the ASCII code
  typedef enum logic [2:0] {
    KEY_DIGIT,
    KEY_PLUS,
    KEY_MINUS,
    KEY_TIMES,
    KEY_DIVIDE,
    KEY_EQUALS,
    KEY_OTHER
  } key_e;

  // Top-level sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FOLD,
    ST_WAIT,
    ST_APPLY,
    ST_EMIT
  } state_e;

  // Multiply/divide unit sequencer
  typedef enum logic [1:0] {
    MD_IDLE,
    MD_RUN,
    MD_FIX
  } md_state_e;

  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_rsp_t;

  localparam logic [7:0] ASCII_ZERO   = 8'h30;
  localparam logic [7:0] ASCII_NINE   = 8'h39;
  localparam logic [7:0] ASCII_PLUS   = 8'h2B;
  localparam logic [7:0] ASCII_MINUS  = 8'h2D;
  localparam logic [7:0] ASCII_TIMES  = 8'h2A;
  localparam logic [7:0] ASCII_SLASH  = 8'h2F;
  localparam logic [7:0] ASCII_EQUALS = 8'h3D;

  function automatic key_e classify(logic [7:0] key);
    key_e cls;
    cls = KEY_OTHER;
    if (key >= ASCII_ZERO && key <= ASCII_NINE) begin
      cls = KEY_DIGIT;
    end else if (key == ASCII_PLUS) begin
      cls = KEY_PLUS;
    end else if (key == ASCII_MINUS) begin
      cls = KEY_MINUS;
    end else if (key == ASCII_TIMES) begin
      cls = KEY_TIMES;
    end else if (key == ASCII_SLASH) begin
      cls = KEY_DIVIDE;
    end else if (key == ASCII_EQUALS) begin
      cls = KEY_EQUALS;
    end
    return cls;
  endfunction

  // Only meaningful for digit keys
  function automatic logic [3:0] digit_of(logic [7:0] key);
    logic [7:0] diff;
    diff = key - ASCII_ZERO;
    return diff[3:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/keypad_infix_calculator.sv */
// Path from accept to out_valid_o: digits, clear and syntax errors go DECODE,
// EMIT; a zero divisor goes DECODE, FOLD, EMIT; an operator with nothing pending
// goes DECODE, FOLD, APPLY, EMIT; a pending times/divide adds WAIT (shared unit).
// Throughput: one item at a time; in_ready_o rises with out_valid_o, and waits
// while an untaken result still holds the output register.
// Reset (rst_ni low, asynchronous): total zero, no pending op, flags clear.
`default_nettype none

`include "keypad_infix_calculator_macros.svh"

module keypad_infix_calculator #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               operation_i,
  input  wire logic [7:0]         key_code_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      shown_total_o,
  output logic                    syntax_error_o,
  output logic                    divide_error_o
);

  kic_pkg::state_e       state_q, state_d;
  logic                  clr_q, clr_d;
  logic [7:0]            key_q, key_d;
  kic_pkg::key_e         key_cls;

  logic [DATA_WIDTH-1:0] total_q, total_d;
  logic [DATA_WIDTH-1:0] digit_q, digit_d;
  logic [DATA_WIDTH-1:0] left_q, left_d;
  logic [DATA_WIDTH-1:0] fold_q, fold_d;
  kic_pkg::pend_e        pend_q, pend_d;
  logic                  neg_q, neg_d;
  logic                  start_q, start_d;
  logic                  have_q, have_d;
  logic                  syn_q, syn_d;
  logic                  dz_q, dz_d;

  logic                  out_valid_q, out_valid_d;
  logic [31:0]           out_total_q, out_total_d;
  logic                  out_syn_q, out_syn_d;
  logic                  out_dz_q, out_dz_d;

  logic                  finish;
  logic                  fold_ok;

  kic_pkg::md_req_t      md_req;
  kic_pkg::md_rsp_t      md_rsp;
  logic [DATA_WIDTH-1:0] md_result;

  assign key_cls = kic_pkg::classify(key_q);

  kic_muldiv #(
    .DataWidth(DATA_WIDTH)
  ) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (md_req),
    .a_i     (left_q),
    .b_i     (digit_q),
    .rsp_o   (md_rsp),
    .result_o(md_result)
  );

  // Sequencer: decode, fold pending op, close term, emit
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    key_d       = key_q;
    total_d     = total_q;
    digit_d     = digit_q;
    left_d      = left_q;
    fold_d      = fold_q;
    pend_d      = pend_q;
    neg_d       = neg_q;
    start_d     = start_q;
    have_d      = have_q;
    syn_d       = syn_q;
    dz_d        = dz_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_total_d = out_total_q;
    out_syn_d   = out_syn_q;
    out_dz_d    = out_dz_q;
    md_req      = '0;
    finish      = 1'b0;
    fold_ok     = 1'b0;

    unique case (state_q)
      kic_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          clr_d   = operation_i;
          key_d   = key_code_i;
          state_d = kic_pkg::ST_DECODE;
        end
      end
      kic_pkg::ST_DECODE: begin
        state_d = kic_pkg::ST_EMIT;
        if (clr_q) begin
          total_d = '0;
          digit_d = '0;
          left_d  = '0;
          pend_d  = kic_pkg::PEND_NONE;
          neg_d   = 1'b0;
          start_d = 1'b1;
          have_d  = 1'b0;
          syn_d   = 1'b0;
          dz_d    = 1'b0;
        end else if (!(syn_q || dz_q)) begin
          unique case (key_cls)
            kic_pkg::KEY_PLUS, kic_pkg::KEY_MINUS: begin
              if (start_q && key_cls == kic_pkg::KEY_MINUS) begin
                // leading minus
                neg_d   = 1'b1;
                have_d  = 1'b0;
                start_d = 1'b0;
              end else if (start_q || !have_q) begin
                syn_d   = 1'b1;
                digit_d = '0;
                have_d  = 1'b0;
              end else begin
                state_d = kic_pkg::ST_FOLD;
              end
            end
            kic_pkg::KEY_TIMES, kic_pkg::KEY_DIVIDE: begin
              if (start_q || !have_q) begin
                syn_d   = 1'b1;
                digit_d = '0;
                have_d  = 1'b0;
              end else begin
                state_d = kic_pkg::ST_FOLD;
              end
            end
            kic_pkg::KEY_EQUALS: begin
              if (!have_q) begin
                syn_d   = 1'b1;
                digit_d = '0;
              end else begin
                state_d = kic_pkg::ST_FOLD;
              end
            end
            kic_pkg::KEY_DIGIT: begin
              // digit * 10 + new digit, wrapping
              start_d = 1'b0;
              have_d  = 1'b1;
              digit_d = (digit_q << 3) + (digit_q << 1)
                      + DATA_WIDTH'(kic_pkg::digit_of(key_q));
            end
            default: begin
              syn_d = 1'b1;
            end
          endcase
        end
      end
      kic_pkg::ST_FOLD: begin
        priority if (pend_q == kic_pkg::PEND_DIV && digit_q == '0) begin
          dz_d   = 1'b1;
          finish = 1'b1;
        end else if (pend_q == kic_pkg::PEND_NONE) begin
          fold_d  = digit_q;
          state_d = kic_pkg::ST_APPLY;
        end else begin
          md_req.start  = 1'b1;
          md_req.is_div = (pend_q == kic_pkg::PEND_DIV);
          state_d       = kic_pkg::ST_WAIT;
        end
      end
      kic_pkg::ST_WAIT: begin
        if (md_rsp.done) begin
          fold_d  = md_result;
          state_d = kic_pkg::ST_APPLY;
        end
      end
      kic_pkg::ST_APPLY: begin
        finish  = 1'b1;
        fold_ok = 1'b1;
      end
      kic_pkg::ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_total_d = 32'($signed(total_q));
          out_syn_d   = syn_q;
          out_dz_d    = dz_q;
          state_d     = kic_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kic_pkg::ST_IDLE;
      end
    endcase

    // Operator wrap-up; a zero divisor leaves total and left factor alone
    if (finish) begin
      state_d = kic_pkg::ST_EMIT;
      digit_d = '0;
      unique case (key_cls)
        kic_pkg::KEY_PLUS, kic_pkg::KEY_MINUS: begin
          if (fold_ok) begin
            total_d = neg_q ? (total_q - fold_q) : (total_q + fold_q);
            pend_d  = kic_pkg::PEND_NONE;
          end
          neg_d  = (key_cls == kic_pkg::KEY_MINUS);
          have_d = 1'b0;
        end
        kic_pkg::KEY_TIMES, kic_pkg::KEY_DIVIDE: begin
          if (fold_ok) begin
            left_d = fold_q;
          end
          pend_d = (key_cls == kic_pkg::KEY_TIMES) ? kic_pkg::PEND_MUL
                                                   : kic_pkg::PEND_DIV;
          have_d = 1'b0;
        end
        kic_pkg::KEY_EQUALS: begin
          if (fold_ok) begin
            total_d = neg_q ? (total_q - fold_q) : (total_q + fold_q);
            pend_d  = kic_pkg::PEND_NONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kic_pkg::ST_IDLE;
      clr_q       <= 1'b0;
      key_q       <= '0;
      total_q     <= '0;
      digit_q     <= '0;
      left_q      <= '0;
      fold_q      <= '0;
      pend_q      <= kic_pkg::PEND_NONE;
      neg_q       <= 1'b0;
      start_q     <= 1'b1;
      have_q      <= 1'b0;
      syn_q       <= 1'b0;
      dz_q        <= 1'b0;
      out_valid_q <= 1'b0;
      out_total_q <= '0;
      out_syn_q   <= 1'b0;
      out_dz_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      key_q       <= key_d;
      total_q     <= total_d;
      digit_q     <= digit_d;
      left_q      <= left_d;
      fold_q      <= fold_d;
      pend_q      <= pend_d;
      neg_q       <= neg_d;
      start_q     <= start_d;
      have_q      <= have_d;
      syn_q       <= syn_d;
      dz_q        <= dz_d;
      out_valid_q <= out_valid_d;
      out_total_q <= out_total_d;
      out_syn_q   <= out_syn_d;
      out_dz_q    <= out_dz_d;
    end
  end

  assign in_ready_o     = (state_q == kic_pkg::ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign shown_total_o  = out_total_q;
  assign syntax_error_o = out_syn_q;
  assign divide_error_o = out_dz_q;

  // Checks
  `KIC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `KIC_ASSERT_NOW(a_unit_only_in_wait, md_rsp.busy, state_q == kic_pkg::ST_WAIT)
  `KIC_ASSERT_NEXT(a_syntax_sticky, syn_q && !(state_q == kic_pkg::ST_DECODE && clr_q), syn_q)
  `KIC_ASSERT_NEXT(a_divzero_sticky, dz_q && !(state_q == kic_pkg::ST_DECODE && clr_q), dz_q)

endmodule

`default_nettype wire

/* rtl/kic_muldiv.sv */
`default_nettype none

// Shared iterative multiply / signed truncating divide, one bit per cycle.
// Iterates in MD_RUN, then enters MD_FIX; done pulses in MD_FIX.
module kic_muldiv #(
  parameter int unsigned DataWidth = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire kic_pkg::md_req_t       req_i,
  input  wire logic [DataWidth-1:0]   a_i,
  input  wire logic [DataWidth-1:0]   b_i,
  output kic_pkg::md_rsp_t            rsp_o,
  output logic      [DataWidth-1:0]   result_o
);

  localparam int unsigned CntW = $clog2(DataWidth);

  kic_pkg::md_state_e   state_q, state_d;
  logic [DataWidth-1:0] acc_q, acc_d;   // product or remainder
  logic [DataWidth-1:0] opa_q, opa_d;   // multiplicand or dividend/quotient
  logic [DataWidth-1:0] opb_q, opb_d;   // multiplier or divisor
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 div_q, div_d;
  logic                 neg_q, neg_d;

  logic [DataWidth:0]   rem_sh;
  logic [DataWidth:0]   rem_diff;

  // Restoring divide step
  assign rem_sh   = {acc_q, opa_q[DataWidth-1]};
  assign rem_diff = rem_sh - {1'b0, opb_q};

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    opa_d   = opa_q;
    opb_d   = opb_q;
    cnt_d   = cnt_q;
    div_d   = div_q;
    neg_d   = neg_q;
    unique case (state_q)
      kic_pkg::MD_IDLE: begin
        if (req_i.start) begin
          state_d = kic_pkg::MD_RUN;
          acc_d   = '0;
          cnt_d   = '0;
          div_d   = req_i.is_div;
          if (req_i.is_div) begin
            // work on magnitudes, sign restored at the end
            opa_d = a_i[DataWidth-1] ? -a_i : a_i;
            opb_d = b_i[DataWidth-1] ? -b_i : b_i;
            neg_d = a_i[DataWidth-1] ^ b_i[DataWidth-1];
          end else begin
            opa_d = a_i;
            opb_d = b_i;
            neg_d = 1'b0;
          end
        end
      end
      kic_pkg::MD_RUN: begin
        if (div_q) begin
          if (!rem_diff[DataWidth]) begin
            acc_d = rem_diff[DataWidth-1:0];
            opa_d = {opa_q[DataWidth-2:0], 1'b1};
          end else begin
            acc_d = rem_sh[DataWidth-1:0];
            opa_d = {opa_q[DataWidth-2:0], 1'b0};
          end
        end else begin
          // shift-add, product wraps at DataWidth bits
          if (opb_q[0]) begin
            acc_d = acc_q + opa_q;
          end
          opa_d = {opa_q[DataWidth-2:0], 1'b0};
          opb_d = {1'b0, opb_q[DataWidth-1:1]};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(DataWidth - 1)) begin
          state_d = kic_pkg::MD_FIX;
        end
      end
      kic_pkg::MD_FIX: begin
        state_d = kic_pkg::MD_IDLE;
      end
      default: begin
        state_d = kic_pkg::MD_IDLE;
      end
    endcase
  end

  // Result with quotient sign fix-up
  always_comb begin
    if (div_q) begin
      result_o = neg_q ? -opa_q : opa_q;
    end else begin
      result_o = acc_q;
    end
  end

  assign rsp_o.busy = (state_q != kic_pkg::MD_IDLE);
  assign rsp_o.done = (state_q == kic_pkg::MD_FIX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kic_pkg::MD_IDLE;
      acc_q   <= '0;
      opa_q   <= '0;
      opb_q   <= '0;
      cnt_q   <= '0;
      div_q   <= 1'b0;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      opa_q   <= opa_d;
      opb_q   <= opb_d;
      cnt_q   <= cnt_d;
      div_q   <= div_d;
      neg_q   <= neg_d;
    end
  end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Command codes on operation_i
  localparam logic CMD_KEY   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam int RAND_ITEMS   = 820;
  localparam int DRAIN_CYCLES = 100;
  localparam int RUN_LIMIT_NS = 5_000_000;

  typedef struct packed {
    logic [31:0] total;
    logic        syn;
    logic        dz;
  } calc_result_t;

  typedef struct {
    logic         op;
    logic [7:0]   key;
    bit           typed;
    calc_result_t res;
  } dir_row_t;

  localparam calc_result_t ALL_CLEAR = '{32'd0, 1'b0, 1'b0};
  localparam calc_result_t SYN_AT_0  = '{32'd0, 1'b1, 1'b0};
  localparam calc_result_t DZ_AT_0   = '{32'd0, 1'b0, 1'b1};

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        operation_i = CMD_CLEAR;
  logic [7:0]  key_code_i  = 8'h00;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic signed [31:0] shown_total_o;
  logic        syntax_error_o;
  logic        divide_error_o;

  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int mismatches   = 0;
  int sent_items   = 0;

  // Calculator state as the predictor sees it
  logic [31:0]    calc_total, calc_digits, calc_factor;
  kic_pkg::pend_e calc_pend;
  bit             calc_neg, calc_fresh, calc_have, calc_syn, calc_dz;

  calc_result_t calc_expected[$];

  // Directed items: expected values typed in where they are obvious
  dir_row_t dir_rows [27] = '{
    '{CMD_CLEAR, 8'h00,                      1'b1, ALL_CLEAR},
    '{CMD_KEY,   kic_pkg::ASCII_PLUS,        1'b1, SYN_AT_0},   // leading plus
    '{CMD_KEY,   kic_pkg::ASCII_ZERO + 8'd5, 1'b1, SYN_AT_0},   // ignored under error
    '{CMD_CLEAR, 8'hFF,                      1'b1, ALL_CLEAR},
    '{CMD_KEY,   kic_pkg::ASCII_MINUS,       1'b1, ALL_CLEAR},  // leading minus
    '{CMD_KEY,   kic_pkg::ASCII_NINE,        1'b1, ALL_CLEAR},
    '{CMD_KEY,   kic_pkg::ASCII_TIMES,       1'b0, ALL_CLEAR},
    '{CMD_KEY,   kic_pkg::ASCII_NINE,        1'b0, ALL_CLEAR},
    '{CMD_KEY,   kic_pkg::ASCII_SLASH,       1'b0, ALL_CLEAR},  // chained times/divide
    '{CMD_KEY,   kic_pkg::ASCII_ZERO + 8'd2, 1'b0, ALL_CLEAR},
    '{CMD_KEY,   kic_pkg::ASCII_EQUALS,      1'b0, ALL_CLEAR},
    '{CMD_KEY,   kic_pkg::ASCII_EQUALS,      1'b0, ALL_CLEAR},  // repeated equals adds zero
    '{CMD_KEY,   kic_pkg::ASCII_ZERO + 8'd7, 1'b0, ALL_CLEAR},
    '{CMD_KEY,   kic_pkg::ASCII_PLUS,        1'b0, ALL_CLEAR},
    '{CMD_KEY,   8'h80,                      1'b0, ALL_CLEAR},  // unknown key
    '{CMD_CLEAR, 8'h55,                      1'b1, ALL_CLEAR},
    '{CMD_KEY,   kic_pkg::ASCII_ZERO + 8'd7, 1'b1, ALL_CLEAR},
    '{CMD_KEY,   kic_pkg::ASCII_SLASH,       1'b1, ALL_CLEAR},
    '{CMD_KEY,   kic_pkg::ASCII_ZERO,        1'b1, ALL_CLEAR},
    '{CMD_KEY,   kic_pkg::ASCII_EQUALS,      1'b1, DZ_AT_0},    // zero divisor
    '{CMD_KEY,   kic_pkg::ASCII_ZERO + 8'd8, 1'b1, DZ_AT_0},
    '{CMD_CLEAR, 8'hAA,                      1'b1, ALL_CLEAR},
    '{CMD_KEY,   kic_pkg::ASCII_EQUALS,      1'b1, SYN_AT_0},   // equals with no number
    '{CMD_CLEAR, 8'h00,                      1'b1, ALL_CLEAR},
    '{CMD_KEY,   kic_pkg::ASCII_TIMES,       1'b1, SYN_AT_0},   // leading times
    '{CMD_CLEAR, 8'h00,                      1'b1, ALL_CLEAR},
    '{CMD_KEY,   kic_pkg::ASCII_SLASH,       1'b1, SYN_AT_0}    // leading divide
  };

  keypad_infix_calculator u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .key_code_i     (key_code_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .shown_total_o  (shown_total_o),
    .syntax_error_o (syntax_error_o),
    .divide_error_o (divide_error_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void calc_clear();
    calc_total  = '0;
    calc_digits = '0;
    calc_factor = '0;
    calc_pend   = kic_pkg::PEND_NONE;
    calc_neg    = 1'b0;
    calc_fresh  = 1'b1;
    calc_have   = 1'b0;
    calc_syn    = 1'b0;
    calc_dz     = 1'b0;
  endfunction

  // Signed division truncating toward zero, wrapping at 32 bits
  function automatic logic [31:0] sdiv_trunc(logic [31:0] n, logic [31:0] d);
    logic [31:0] a, b, q;
    a = n[31] ? -n : n;
    b = d[31] ? -d : d;
    q = a / b;
    return (n[31] ^ d[31]) ? -q : q;
  endfunction

  // Applies the pending times/divide; 0 on a zero divisor
  function automatic bit apply_pending(output logic [31:0] res);
    res = calc_digits;
    if (calc_pend == kic_pkg::PEND_MUL) begin
      res = calc_factor * calc_digits;
    end else if (calc_pend == kic_pkg::PEND_DIV) begin
      if (calc_digits == '0) begin
        calc_dz = 1'b1;
        return 1'b0;
      end
      res = sdiv_trunc(calc_factor, calc_digits);
    end
    return 1'b1;
  endfunction

  function automatic void close_term();
    logic [31:0] t;
    if (!apply_pending(t)) return;
    calc_total = calc_neg ? calc_total - t : calc_total + t;
    calc_pend  = kic_pkg::PEND_NONE;
  endfunction

  function automatic void press_key(logic [7:0] k);
    logic [31:0] t;
    if (calc_syn || calc_dz) return;
    if (k == kic_pkg::ASCII_PLUS || k == kic_pkg::ASCII_MINUS) begin
      if (calc_fresh && k == kic_pkg::ASCII_MINUS) begin
        calc_neg   = 1'b1;
        calc_have  = 1'b0;
        calc_fresh = 1'b0;
        return;
      end
      if (calc_fresh || !calc_have) begin
        calc_syn = 1'b1;
      end else begin
        close_term();
        calc_neg = (k == kic_pkg::ASCII_MINUS);
      end
      calc_digits = '0;
      calc_have   = 1'b0;
    end else if (k == kic_pkg::ASCII_TIMES || k == kic_pkg::ASCII_SLASH) begin
      if (calc_fresh || !calc_have) begin
        calc_syn = 1'b1;
      end else begin
        if (apply_pending(t)) calc_factor = t;
        calc_pend = (k == kic_pkg::ASCII_TIMES) ? kic_pkg::PEND_MUL : kic_pkg::PEND_DIV;
      end
      calc_digits = '0;
      calc_have   = 1'b0;
    end else if (k == kic_pkg::ASCII_EQUALS) begin
      if (!calc_have) calc_syn = 1'b1;
      else close_term();
      calc_digits = '0;
    end else if (k >= kic_pkg::ASCII_ZERO && k <= kic_pkg::ASCII_NINE) begin
      calc_fresh  = 1'b0;
      calc_digits = calc_digits * 32'd10 + 32'(k - kic_pkg::ASCII_ZERO);
      calc_have   = 1'b1;
    end else begin
      calc_syn = 1'b1;
    end
  endfunction

  // Offers one item, waits for it to be taken, then records what it must show
  task automatic send_item(input logic op, input logic [7:0] key,
                           input bit typed = 1'b0, input calc_result_t res = '0);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    key_code_i  <= key;
    do @(posedge clk_i); while (!in_ready_o);
    sent_items++;
    if (op == CMD_CLEAR) calc_clear();
    else press_key(key);
    calc_expected.push_back(typed ? res : calc_result_t'{calc_total, calc_syn, calc_dz});
  endtask

  // Mostly short numbers, now and then long enough to wrap
  task automatic send_number();
    int n;
    n = ($urandom_range(15) == 0) ? $urandom_range(12, 9) : $urandom_range(3, 1);
    repeat (n) send_item(CMD_KEY, kic_pkg::ASCII_ZERO + 8'($urandom_range(9)));
  endtask

  // One well-formed expression with random content, sometimes missing a number
  task automatic send_expression();
    int terms;
    logic [7:0] op_key;
    if (calc_syn || calc_dz || $urandom_range(3) == 0) send_item(CMD_CLEAR, 8'($urandom));
    if ($urandom_range(3) == 0) send_item(CMD_KEY, kic_pkg::ASCII_MINUS);
    terms = $urandom_range(4, 1);
    for (int i = 0; i < terms; i++) begin
      if ($urandom_range(19) != 0) send_number();
      if (i < terms - 1) begin
        case ($urandom_range(3))
          0: op_key = kic_pkg::ASCII_PLUS;
          1: op_key = kic_pkg::ASCII_MINUS;
          2: op_key = kic_pkg::ASCII_TIMES;
          default: op_key = kic_pkg::ASCII_SLASH;
        endcase
        send_item(CMD_KEY, op_key);
      end
    end
    send_item(CMD_KEY, kic_pkg::ASCII_EQUALS);
    if ($urandom_range(7) == 0) send_item(CMD_KEY, kic_pkg::ASCII_EQUALS);
  endtask

  // Result side: random stalls, compare each taken item with the oldest expectation
  always @(posedge clk_i) begin : result_check
    calc_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (calc_expected.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item, total %0d syntax %0b divide %0b", $time,
                 shown_total_o, syntax_error_o, divide_error_o);
      end else begin
        want = calc_expected.pop_front();
        if (shown_total_o !== want.total) begin
          mismatches++;
          $display("%0t: shown_total expected %0d got %0d", $time,
                   $signed(want.total), shown_total_o);
        end
        if (syntax_error_o !== want.syn) begin
          mismatches++;
          $display("%0t: syntax_error expected %0b got %0b", $time, want.syn,
                   syntax_error_o);
        end
        if (divide_error_o !== want.dz) begin
          mismatches++;
          $display("%0t: divide_error expected %0b got %0b", $time, want.dz,
                   divide_error_o);
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= out_idle_pct);
  end

  initial begin
    #RUN_LIMIT_NS;
    $display("FAIL keypad_infix_calculator");
    $finish;
  end

  initial begin : stimulus
    int base;
    int idle_in [3]  = '{25, 68, 0};
    int idle_out [3] = '{68, 25, 0};
    calc_clear();
    in_idle_pct  = idle_in[0];
    out_idle_pct = idle_out[0];
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].op, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].res);
    end

    // Random part, three idling phases
    base = sent_items;
    for (int p = 0; p < 3; p++) begin
      in_idle_pct  = idle_in[p];
      out_idle_pct = idle_out[p];
      while (sent_items < base + (p + 1) * RAND_ITEMS / 3) begin
        if ($urandom_range(9) == 0) begin
          // noise: arbitrary codes, occasional clear
          repeat ($urandom_range(4, 1)) begin
            send_item(($urandom_range(7) == 0) ? CMD_CLEAR : CMD_KEY, 8'($urandom));
          end
        end else begin
          send_expression();
        end
      end
    end
    in_valid_i <= 1'b0;

    while (calc_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS keypad_infix_calculator");
    end else begin
      $display("FAIL keypad_infix_calculator");
    end
    $finish;
  end

endmodule
